// ===== rtl/core/mptk_pkg.sv =====
// ----------------------------------------------------------------------------
// mptk_pkg: shared types and constants
// Widths, the cell count and the per-cycle step command for the
// k-transaction best-profit cell row.
// ----------------------------------------------------------------------------
package mptk_pkg;

   localparam int K_MAX    = 8;
   localparam int K_IDX_W  = (K_MAX > 1) ? $clog2(K_MAX) : 1;
   localparam int PRICE_W  = 16;
   localparam int PROFIT_W = 32;
   localparam int LIMIT_W  = 4;
   localparam int KSEL_W   = 7;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(2);

   typedef logic [PRICE_W-1:0]  price_type;
   typedef logic [PROFIT_W-1:0] profit_type;
   typedef logic [LIMIT_W-1:0]  limit_type;

   localparam profit_type PROFIT_TOP = '1;

   typedef struct packed {
      logic                      update;
      logic                      clear;
      logic signed [PRICE_W:0]   diff;
      logic        [PRICE_W-1:0] gain;
   } mptk_step_type;

endpackage

// ===== rtl/core/mptk_ifs.sv =====
// ----------------------------------------------------------------------------
// mptk_ifs: channel interfaces
// Price input, profit result and limit register write channels.
// ----------------------------------------------------------------------------
interface mptk_req_if import mptk_pkg::*; ();
   logic      valid;
   logic      ready;
   price_type price;
   logic      first_day;

   modport source (output valid, output price, output first_day, input ready);
   modport sink   (input valid, input price, input first_day, output ready);
endinterface

interface mptk_rsp_if import mptk_pkg::*; ();
   logic       valid;
   logic       ready;
   profit_type best_profit;

   modport source (output valid, output best_profit, input ready);
   modport sink   (input valid, input best_profit, output ready);
endinterface

interface mptk_csr_if import mptk_pkg::*; ();
   logic      valid;
   logic      ready;
   limit_type max_transactions;

   modport source (output valid, output max_transactions, input ready);
   modport sink   (input valid, input max_transactions, output ready);
endinterface

// ===== rtl/core/mptk_cell.sv =====
// ----------------------------------------------------------------------------
// mptk_cell: one transaction-count cell
// Holds local and global best for one transaction count and updates them
// from the neighbor's global best and the day's price move.
// ----------------------------------------------------------------------------
module mptk_cell import mptk_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  mptk_step_type step,
   input  profit_type    below,
   output profit_type    global_q,
   output profit_type    global_next
);

   profit_type local_ff, local_in;
   profit_type global_ff, global_in;

   logic        [PROFIT_W:0]   open_sum;
   logic signed [PROFIT_W+1:0] ext_sum;
   profit_type                 open_c;
   profit_type                 ext_c;
   profit_type                 loc;

   always_comb begin
      open_sum = {1'b0, below} + {{(PROFIT_W + 1 - PRICE_W){1'b0}}, step.gain};
      ext_sum  = $signed({2'b00, local_ff}) +
                 {{(PROFIT_W + 1 - PRICE_W){step.diff[PRICE_W]}}, step.diff};
      open_c   = open_sum[PROFIT_W] ? PROFIT_TOP : open_sum[PROFIT_W-1:0];
      if (ext_sum[PROFIT_W+1]) begin
         ext_c = '0;
      end else if (ext_sum[PROFIT_W]) begin
         ext_c = PROFIT_TOP;
      end else begin
         ext_c = ext_sum[PROFIT_W-1:0];
      end
      loc = (open_c > ext_c) ? open_c : ext_c;

      local_in  = local_ff;
      global_in = global_ff;
      if (step.update) begin
         if (step.clear) begin
            local_in  = '0;
            global_in = '0;
         end else begin
            local_in  = loc;
            global_in = (loc > global_ff) ? loc : global_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_ff  <= '0;
         global_ff <= '0;
      end else begin
         local_ff  <= local_in;
         global_ff <= global_in;
      end
   end

   assign global_q    = global_ff;
   assign global_next = global_in;

   a_global_covers_local: assert property (@(posedge clock) disable iff (reset)
      global_ff >= local_ff)
      else $error("global best below local best");

endmodule

// ===== rtl/core/mptk_chain.sv =====
// ----------------------------------------------------------------------------
// mptk_chain: row of transaction-count cells
// Cell j takes the global best of cell j-1; cell 0 sees zero.
// ----------------------------------------------------------------------------
module mptk_chain import mptk_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  mptk_step_type step,
   output profit_type    global_next [K_MAX]
);

   profit_type global_q [K_MAX];
   profit_type below    [K_MAX];

   for (genvar j = 0; j < K_MAX; j++) begin : g_cell
      if (j == 0) begin : g_first
         assign below[j] = '0;
      end else begin : g_rest
         assign below[j] = global_q[j-1];
      end

      mptk_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .step        (step),
         .below       (below[j]),
         .global_q    (global_q[j]),
         .global_next (global_next[j])
      );
   end

endmodule

// ===== rtl/core/max_profit_k_transactions_unit.sv =====
// ----------------------------------------------------------------------------
// max_profit_k_transactions_unit: best profit over k stock transactions
// Streams daily prices and returns the running best profit with at most
// the configured number of buy/sell transactions.
// ----------------------------------------------------------------------------
// Usage:
//   req: one price per transfer; first_day starts a new series and clears
//        all cells. With no first_day since reset it continues from price 0.
//   rsp: one best_profit per req transfer, in order, saturating at 2^32-1.
//   csr: writes max_transactions (always ready); write only while idle.
//        Zero gives profit 0, values above K_MAX act as K_MAX.
//   Output: the output register takes the result with the req transfer.
//   Throughput: one item per cycle while rsp is not held; all K_MAX cells
//   update in the same cycle, each from its neighbor's previous global best.
//   Stall: while rsp is held, req.ready stays low once the output register
//   is full; it rises again in the cycle rsp is taken.
//   Reset: cells, previous price and rsp.valid clear; the limit returns to 2.
// ----------------------------------------------------------------------------
module max_profit_k_transactions_unit import mptk_pkg::*; (
   input logic      clock,
   input logic      reset,
   mptk_req_if.sink   req,
   mptk_rsp_if.source rsp,
   mptk_csr_if.sink   csr
);

   limit_type     limit_ff, limit_in;
   price_type     prev_ff, prev_in;
   logic          rsp_valid_ff, rsp_valid_in;
   profit_type    rsp_data_ff, rsp_data_in;
   logic          take;
   mptk_step_type step;
   profit_type    global_next [K_MAX];
   logic [KSEL_W-1:0] k_eff;
   logic [KSEL_W-1:0] k_idx;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign csr.ready = 1'b1;
   assign take      = req.valid && req.ready;

   always_comb begin
      step.update = take;
      step.clear  = req.first_day;
      step.diff   = $signed({1'b0, req.price}) - $signed({1'b0, prev_ff});
      step.gain   = step.diff[PRICE_W] ? '0 : step.diff[PRICE_W-1:0];
   end

   mptk_chain u_chain (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .global_next (global_next)
   );

   always_comb begin
      k_eff = ({{(KSEL_W - LIMIT_W){1'b0}}, limit_ff} > KSEL_W'(K_MAX)) ?
              KSEL_W'(K_MAX) : {{(KSEL_W - LIMIT_W){1'b0}}, limit_ff};
      k_idx = k_eff - KSEL_W'(1);

      limit_in     = (csr.valid && csr.ready) ? csr.max_transactions : limit_ff;
      prev_in      = take ? req.price : prev_ff;
      rsp_valid_in = take || (rsp_valid_ff && !rsp.ready);
      rsp_data_in  = rsp_data_ff;
      if (take) begin
         rsp_data_in = (k_eff == '0) ? '0 : global_next[k_idx[K_IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.best_profit = rsp_data_ff;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result pending after reset");

   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   a_first_zero: assert property (@(posedge clock) disable iff (reset)
      take && req.first_day |=> rsp_data_ff == '0)
      else $error("first day result not zero");

   a_limit_zero: assert property (@(posedge clock) disable iff (reset)
      take && limit_ff == '0 |=> rsp_data_ff == '0)
      else $error("zero limit result not zero");

   a_prev_tracks: assert property (@(posedge clock) disable iff (reset)
      take |=> prev_ff == $past(req.price))
      else $error("previous price not stored");

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for max_profit_k_transactions_unit
// Drives price series into the unit and checks every best_profit transfer
// against an in-bench model of the k-transaction profit cells or a pinned
// value. A short directed table covers reset, extreme prices and limit
// corners. Random series under changing limits and three idling patterns follow.
// ----------------------------------------------------------------------------
module tb;
   import mptk_pkg::*;

   localparam int NUM_DIRECTED = 23;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAX_REPORTS  = 20;

   typedef struct {
      logic       set_limit;
      limit_type  limit;
      price_type  price;
      logic       first_day;
      logic       pinned;
      profit_type want;
   } day_row_type;

   typedef struct {
      logic       pinned;
      profit_type want;
   } day_note_type;

   logic clock;
   logic reset;

   mptk_req_if req_ch ();
   mptk_rsp_if rsp_ch ();
   mptk_csr_if csr_ch ();

   max_profit_k_transactions_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   // bench copy of the cell row
   limit_type  txn_limit;
   price_type  last_price;
   profit_type cell_local  [K_MAX];
   profit_type cell_global [K_MAX];

   profit_type   expected_profit [$];
   day_note_type offer_notes [$];
   day_row_type  directed_rows [NUM_DIRECTED];

   int send_idle_pct;
   int recv_idle_pct;
   int holdoff_left;
   int errors;
   int accepted_days;
   int checked_results;
   int limit_writes;
   int cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) cycles <= cycles + 1;

   initial begin : watchdog
      while (cycles < CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d results pending", cycles,
               expected_profit.size());
      $display("TB_ERROR");
      $finish;
   end

   function automatic profit_type clamp_profit(longint v);
      if (v < 0) return '0;
      if (v > longint'(PROFIT_TOP)) return PROFIT_TOP;
      return profit_type'(v);
   endfunction

   function automatic profit_type advance_day(price_type p, logic first);
      longint diff, gain, below, open_new, extend;
      int     j, k;
      if (first) begin
         for (j = 0; j < K_MAX; j++) begin
            cell_local[j]  = '0;
            cell_global[j] = '0;
         end
      end else begin
         diff = longint'(p) - longint'(last_price);
         gain = (diff > 0) ? diff : 0;
         // descending keeps the lower neighbor at yesterday's value
         for (j = K_MAX - 1; j >= 0; j--) begin
            below = 0;
            if (j >= 1) below = longint'(cell_global[j-1]);
            open_new = below + gain;
            extend   = longint'(cell_local[j]) + diff;
            cell_local[j] = clamp_profit((open_new > extend) ? open_new : extend);
            if (cell_local[j] > cell_global[j]) cell_global[j] = cell_local[j];
         end
      end
      last_price = p;
      k = int'(txn_limit);
      if (k > K_MAX) k = K_MAX;
      if (k == 0) return '0;
      return cell_global[k-1];
   endfunction

   always @(posedge clock) begin : monitor
      day_note_type note;
      profit_type   want;
      int           j;
      if (reset) begin
         txn_limit  = LIMIT_RESET;
         last_price = '0;
         for (j = 0; j < K_MAX; j++) begin
            cell_local[j]  = '0;
            cell_global[j] = '0;
         end
      end else begin
         if (csr_ch.valid && csr_ch.ready) txn_limit = csr_ch.max_transactions;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_profit.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: unexpected result, actual %0d", $time,
                           rsp_ch.best_profit);
            end else begin
               want = expected_profit.pop_front();
               checked_results++;
               if (rsp_ch.best_profit !== want) begin
                  errors++;
                  if (errors <= MAX_REPORTS)
                     $display("%0t: best_profit mismatch, expected %0d, actual %0d",
                              $time, want, rsp_ch.best_profit);
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            note = offer_notes.pop_front();
            want = advance_day(req_ch.price, req_ch.first_day);
            expected_profit.push_back(note.pinned ? note.want : want);
            accepted_days++;
         end
      end
   end

   // receiver: random ready, or a counted hold-off when requested
   initial begin : receiver
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_left > 0) begin
            rsp_ch.ready <= 1'b0;
            holdoff_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // valid stays high after a transfer; the next call either idles or reloads
   task automatic offer_day(price_type p, logic first, logic pinned, profit_type want);
      day_note_type note;
      int           gap;
      note.pinned = pinned;
      note.want   = want;
      offer_notes.push_back(note);
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.price     <= p;
      req_ch.first_day <= first;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic settle_stream();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (expected_profit.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_limit(limit_type v);
      csr_ch.valid            <= 1'b1;
      csr_ch.max_transactions <= v;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      limit_writes++;
   endtask

   task automatic run_random_phase(int items);
      int        sent, series, run_len, mode, i, cur;
      limit_type pick;
      price_type p;
      logic      first;
      sent = 0;
      while (sent < items) begin
         settle_stream();
         case ($urandom_range(7))
            0:       pick = 4'd0;
            1:       pick = 4'd15;
            2:       pick = 4'd8;
            3:       pick = 4'd1;
            default: pick = limit_type'($urandom_range(15));
         endcase
         write_limit(pick);
         for (series = $urandom_range(1, 3); series > 0; series--) begin
            run_len = $urandom_range(1, 40);
            mode    = $urandom_range(2);
            cur     = $urandom_range(65535);
            for (i = 0; i < run_len; i++) begin
               case (mode)
                  0: p = price_type'($urandom_range(65535));
                  1: begin
                     cur = cur + int'($urandom_range(4000)) - 2000;
                     if (cur < 0) cur = 0;
                     if (cur > 65535) cur = 65535;
                     p = price_type'(cur);
                  end
                  default: begin
                     if ($urandom_range(9) == 0)
                        p = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                     else
                        p = price_type'($urandom_range(15));
                  end
               endcase
               if (i == 0) first = ($urandom_range(7) != 0);
               else        first = ($urandom_range(49) == 0);
               offer_day(p, first, 1'b0, '0);
               sent++;
            end
         end
      end
   endtask

   initial begin : stimulus
      int i;
      directed_rows = '{
         '{1'b0, 4'd0,  16'd100,   1'b0, 1'b1, 32'd100}, // no first day since reset
         '{1'b0, 4'd0,  16'hFFFF,  1'b1, 1'b1, 32'd0},   // first day at top price
         '{1'b0, 4'd0,  16'h0000,  1'b0, 1'b0, 32'd0},
         '{1'b0, 4'd0,  16'hFFFF,  1'b0, 1'b0, 32'd0},
         '{1'b0, 4'd0,  16'h0000,  1'b0, 1'b0, 32'd0},
         '{1'b0, 4'd0,  16'hFFFF,  1'b0, 1'b0, 32'd0},
         '{1'b0, 4'd0,  16'd1234,  1'b0, 1'b0, 32'd0},
         '{1'b1, 4'd0,  16'hFFFF,  1'b0, 1'b1, 32'd0},   // limit zero
         '{1'b0, 4'd0,  16'h0000,  1'b1, 1'b1, 32'd0},
         '{1'b1, 4'd15, 16'hFFFF,  1'b0, 1'b0, 32'd0},   // limit above K_MAX
         '{1'b0, 4'd0,  16'h0000,  1'b0, 1'b0, 32'd0},
         '{1'b0, 4'd0,  16'hFFFF,  1'b0, 1'b0, 32'd0},
         '{1'b0, 4'd0,  16'h0000,  1'b0, 1'b0, 32'd0},
         '{1'b0, 4'd0,  16'hFFFF,  1'b0, 1'b0, 32'd0},
         '{1'b0, 4'd0,  16'h0000,  1'b0, 1'b0, 32'd0},
         '{1'b1, 4'd8,  16'hFFFF,  1'b0, 1'b0, 32'd0},
         '{1'b0, 4'd0,  16'h0000,  1'b0, 1'b0, 32'd0},
         '{1'b1, 4'd1,  16'd30000, 1'b1, 1'b1, 32'd0},
         '{1'b0, 4'd0,  16'hFFFF,  1'b0, 1'b0, 32'd0},
         '{1'b0, 4'd0,  16'h0000,  1'b0, 1'b0, 32'd0},
         '{1'b0, 4'd0,  16'hFFFF,  1'b0, 1'b0, 32'd0},
         '{1'b1, 4'd2,  16'h0000,  1'b0, 1'b0, 32'd0},
         '{1'b0, 4'd0,  16'hFFFF,  1'b0, 1'b0, 32'd0}
      };
      req_ch.valid            = 1'b0;
      req_ch.price            = '0;
      req_ch.first_day        = 1'b0;
      csr_ch.valid            = 1'b0;
      csr_ch.max_transactions = LIMIT_RESET;
      send_idle_pct = 23;
      recv_idle_pct = 50;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < NUM_DIRECTED; i++) begin
         if (directed_rows[i].set_limit) begin
            settle_stream();
            write_limit(directed_rows[i].limit);
         end
         offer_day(directed_rows[i].price, directed_rows[i].first_day,
                   directed_rows[i].pinned, directed_rows[i].want);
      end

      // long receiver hold-off while prices keep coming
      settle_stream();
      holdoff_left = 60;
      offer_day(price_type'($urandom_range(65535)), 1'b1, 1'b0, '0);
      for (i = 0; i < 20; i++)
         offer_day(price_type'($urandom_range(65535)), 1'b0, 1'b0, '0);

      run_random_phase(600);
      settle_stream();
      send_idle_pct = 50;
      recv_idle_pct = 23;
      run_random_phase(620);
      settle_stream();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random_phase(640);
      settle_stream();
      repeat (5) @(posedge clock);

      if (expected_profit.size() != 0) begin
         errors++;
         $display("%0t: %0d results never arrived", $time, expected_profit.size());
      end
      $display("%0d price transfers, %0d results checked, %0d limit writes",
               accepted_days, checked_results, limit_writes);
      $display("limits 0..15, extreme prices, reset carry-over, hold-off, three idle mixes");
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
